// ===== rtl/uhmf_pkg.sv =====
// ----------------------------------------------------------------------------
// uhmf_pkg
// Shared types and constants for the UTF-8 Hebrew mark filter.
// ----------------------------------------------------------------------------
package uhmf_pkg;

  localparam int unsigned QueueDepth = 4;

  localparam logic [1:0] ST_DATA = 2'd0;
  localparam logic [1:0] ST_OK   = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  localparam logic CFG_STRIP_MARKS = 1'b0;
  localparam logic CFG_MAP_HYPHEN  = 1'b1;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       has_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] status;
    logic       marks_found;
    logic       last_of_run;
  } out_item_t;

  typedef struct packed {
    logic strip_marks;
    logic map_hyphen;
  } cfg_t;

  // One queued operation: 0..4 encoded bytes, then an optional end status.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      n;
    logic            has_end;
    logic [1:0]      status;
    logic            marks;
  } op_t;

endpackage

// ===== rtl/uhmf_front.sv =====
// ----------------------------------------------------------------------------
// uhmf_front
// Decodes input bytes into code points, filters them and encodes each
// surviving code point into an operation for the back end.
// ----------------------------------------------------------------------------
module uhmf_front import uhmf_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     accept_i,
  input  in_item_t item_i,
  input  cfg_t     cfg_i,
  output op_t      op_o,
  output logic     op_valid_o
);

  logic [1:0]  pend_q, pend_d;
  logic [20:0] acc_q, acc_d;
  logic        err_q, err_d;
  logic        mark_q, mark_d;

  logic        fin;
  logic [20:0] cp_raw;
  logic [20:0] cp;
  logic        is_mark;
  logic [7:0]  b;

  function automatic logic hebrew_mark(logic [20:0] c);
    return (c >= 21'h000591 && c <= 21'h0005BD) || c == 21'h0005BF ||
           (c >= 21'h0005C1 && c <= 21'h0005C2) ||
           (c >= 21'h0005C4 && c <= 21'h0005C5) || c == 21'h0005C7;
  endfunction

  assign b = item_i.in_byte;

  always_comb begin
    pend_d = pend_q;
    acc_d  = acc_q;
    err_d  = err_q;
    mark_d = mark_q;
    fin    = 1'b0;
    cp_raw = '0;
    if (item_i.has_byte && !err_q) begin
      if (pend_q != 2'd0) begin
        acc_d  = {acc_q[14:0], b[5:0]};
        pend_d = pend_q - 2'd1;
        if (pend_q == 2'd1) begin
          fin    = 1'b1;
          cp_raw = acc_d;
        end
      end else if (b[7] == 1'b0) begin
        fin    = 1'b1;
        cp_raw = {13'd0, b};
      end else if (b[7:5] == 3'b110) begin
        acc_d  = {16'd0, b[4:0]};
        pend_d = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
        acc_d  = {17'd0, b[3:0]};
        pend_d = 2'd2;
      end else if (b[7:3] == 5'b11110) begin
        acc_d  = {18'd0, b[2:0]};
        pend_d = 2'd3;
      end else begin
        err_d = 1'b1;
      end
    end

    is_mark = fin && hebrew_mark(cp_raw);
    if (is_mark) begin
      mark_d = 1'b1;
    end

    cp = cp_raw;
    if (cfg_i.map_hyphen && cp_raw == 21'h00002D) begin
      cp = 21'h0005BE;
    end

    op_o = '0;
    if (fin && !(is_mark && cfg_i.strip_marks)) begin
      if (cp <= 21'h00007F) begin
        op_o.n        = 3'd1;
        op_o.bytes[0] = cp[7:0];
      end else if (cp <= 21'h0007FF) begin
        op_o.n        = 3'd2;
        op_o.bytes[0] = {3'b110, cp[10:6]};
        op_o.bytes[1] = {2'b10, cp[5:0]};
      end else if (cp <= 21'h00FFFF) begin
        op_o.n        = 3'd3;
        op_o.bytes[0] = {4'b1110, cp[15:12]};
        op_o.bytes[1] = {2'b10, cp[11:6]};
        op_o.bytes[2] = {2'b10, cp[5:0]};
      end else begin
        op_o.n        = 3'd4;
        op_o.bytes[0] = {5'b11110, cp[20:18]};
        op_o.bytes[1] = {2'b10, cp[17:12]};
        op_o.bytes[2] = {2'b10, cp[11:6]};
        op_o.bytes[3] = {2'b10, cp[5:0]};
      end
    end

    if (item_i.end_of_text) begin
      op_o.has_end = 1'b1;
      op_o.status  = (err_d || pend_d != 2'd0) ? ST_BAD : ST_OK;
      op_o.marks   = mark_d;
      pend_d = '0;
      acc_d  = '0;
      err_d  = 1'b0;
      mark_d = 1'b0;
    end
  end

  assign op_valid_o = accept_i && (op_o.n != 3'd0 || op_o.has_end);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      acc_q  <= '0;
      err_q  <= 1'b0;
      mark_q <= 1'b0;
    end else if (accept_i) begin
      pend_q <= pend_d;
      acc_q  <= acc_d;
      err_q  <= err_d;
      mark_q <= mark_d;
    end
  end

endmodule

// ===== rtl/uhmf_queue.sv =====
// ----------------------------------------------------------------------------
// uhmf_queue
// Small operation queue between the decode front end and the output back end.
// ----------------------------------------------------------------------------
module uhmf_queue import uhmf_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  op_t  data_i,
  output logic full_o,
  input  logic pop_i,
  output op_t  data_o,
  output logic empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  op_t             mem [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == LastPtr) ? '0 : wr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == LastPtr) ? '0 : rd_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

// ===== rtl/uhmf_back.sv =====
// ----------------------------------------------------------------------------
// uhmf_back
// Holds the current operation and hands out its bytes and end status one
// result item per cycle while pop_i is high.
// ----------------------------------------------------------------------------
module uhmf_back import uhmf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  op_t       op_i,
  input  logic      op_empty_i,
  output logic      op_pop_o,
  output out_item_t out_o,
  output logic      empty_o,
  input  logic      pop_i
);

  op_t        cur_q;
  logic       cur_v_q;
  logic [2:0] idx_q;
  logic       is_data;
  logic       last;

  assign is_data = idx_q < cur_q.n;
  assign last    = cur_q.has_end ? (idx_q == cur_q.n) : (idx_q == cur_q.n - 3'd1);

  always_comb begin
    out_o = '0;
    if (is_data) begin
      out_o.out_byte = cur_q.bytes[idx_q[1:0]];
      out_o.status   = ST_DATA;
    end else begin
      out_o.status      = cur_q.status;
      out_o.marks_found = cur_q.marks;
    end
    out_o.last_of_run = last;
  end

  assign empty_o  = !cur_v_q;
  assign op_pop_o = (!cur_v_q || (pop_i && last)) && !op_empty_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_v_q <= 1'b0;
      idx_q   <= '0;
    end else if (op_pop_o) begin
      cur_v_q <= 1'b1;
      idx_q   <= '0;
    end else if (cur_v_q && pop_i) begin
      if (last) begin
        cur_v_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_pop_o) begin
      cur_q <= op_i;
    end
  end

  a_op_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_v_q |-> (cur_q.n <= 3'd4) && (cur_q.n != 3'd0 || cur_q.has_end))
    else $error("uhmf_back: malformed operation held");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_v_q |-> (idx_q < cur_q.n) || (cur_q.has_end && idx_q == cur_q.n))
    else $error("uhmf_back: result index out of range");

  a_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_pop_o |=> cur_v_q && idx_q == 3'd0)
    else $error("uhmf_back: operation load failed");

endmodule

// ===== rtl/utf8_hebrew_mark_filter.sv =====
// ----------------------------------------------------------------------------
// utf8_hebrew_mark_filter
// Lenient UTF-8 decoder that can drop Hebrew marks, can map hyphen to maqaf,
// and re-encodes each code point in shortest form.
// ----------------------------------------------------------------------------
// One input item is taken per cycle while the operation queue has room. The
// front end decodes and encodes an item in the cycle it is accepted and
// writes at most one operation to the queue; the back end delivers one result
// item per cycle while pop is high, so an item that yields k results (0 to 5)
// holds the output side until all k are popped; its first result appears once
// its operation has passed the queue into the back end. Sustained input rate
// is one item per cycle when results average one per input, else output-paced.
// ----------------------------------------------------------------------------
module utf8_hebrew_mark_filter import uhmf_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_i,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_o,
  input  logic      cfg_we_i,
  input  logic      cfg_idx_i,
  input  logic      cfg_wdata_i
);

  cfg_t cfg_q;
  op_t  fr_op, q_op;
  logic fr_valid, q_empty, q_pop, accept;

  assign accept = push && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.strip_marks <= 1'b1;
      cfg_q.map_hyphen  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_STRIP_MARKS: cfg_q.strip_marks <= cfg_wdata_i;
        CFG_MAP_HYPHEN:  cfg_q.map_hyphen  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  uhmf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .item_i     (in_i),
    .cfg_i      (cfg_q),
    .op_o       (fr_op),
    .op_valid_o (fr_valid)
  );

  uhmf_queue #(.Depth(Depth)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fr_valid),
    .data_i  (fr_op),
    .full_o  (full),
    .pop_i   (q_pop),
    .data_o  (q_op),
    .empty_o (q_empty)
  );

  uhmf_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_i       (q_op),
    .op_empty_i (q_empty),
    .op_pop_o   (q_pop),
    .out_o      (out_o),
    .empty_o    (empty),
    .pop_i      (pop)
  );

endmodule
